### hw/rtl/pcu_pkg.sv
// Shared constants, types and saturation helpers of the perceptron engine.
// No dependencies; used by the interfaces, the result queue and the top level.
package pcu_pkg;

    localparam int FEATURES  = 40;
    localparam int ADDR_W    = (FEATURES > 1) ? $clog2(FEATURES) : 1;
    localparam int IDX_W     = 6;
    localparam int FEAT_W    = 16;
    localparam int W_W       = 32;
    localparam int SUM_W     = 48;
    localparam int LOSS_W    = 47;
    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = OUT_PTR_W + 1;

    localparam logic CMD_CLASSIFY = 1'b0;
    localparam logic CMD_UPDATE   = 1'b1;

    // 1.0 in Q24.8
    localparam logic signed [W_W:0] BIAS_STEP = (W_W + 1)'(256);

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W - 1){1'b0}}};
    localparam logic signed [W_W-1:0]   W_MAX   = {1'b0, {(W_W - 1){1'b1}}};
    localparam logic signed [W_W-1:0]   W_MIN   = {1'b1, {(W_W - 1){1'b0}}};

    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic signed [W_W-1:0]    t_weight;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic signed [FEAT_W-1:0] t_feat;

    typedef struct packed {
        t_sum              score;
        logic              pred;
        logic              miss;
        logic [LOSS_W-1:0] loss;
    } t_result;

    // one guard bit in, clamp to the signed range
    function automatic t_sum sat_sum(input logic signed [SUM_W:0] v);
        t_sum r;
        if (v[SUM_W] != v[SUM_W-1]) begin
            r = v[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            r = v[SUM_W-1:0];
        end
        return r;
    endfunction

    function automatic t_weight sat_weight(input logic signed [W_W:0] v);
        t_weight r;
        if (v[W_W] != v[W_W-1]) begin
            r = v[W_W] ? W_MIN : W_MAX;
        end else begin
            r = v[W_W-1:0];
        end
        return r;
    endfunction

endpackage

### hw/rtl/pcu_req_if.sv
// Request channel of the perceptron engine: valid/ready plus one feature.
// Depends on pcu_pkg for field widths.
interface pcu_req_if import pcu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              command;
    logic [IDX_W-1:0]  feature_index;
    t_feat             feature_value;
    logic              label_positive;
    logic              last;

    modport source (output valid, command, feature_index, feature_value,
                    label_positive, last, input ready);
    modport sink   (input valid, command, feature_index, feature_value,
                    label_positive, last, output ready);
endinterface

### hw/rtl/pcu_rsp_if.sv
// Result channel of the perceptron engine: valid/ready plus one classification.
// Depends on pcu_pkg for field widths.
interface pcu_rsp_if import pcu_pkg::*; ();
    logic              valid;
    logic              ready;
    t_sum              score;
    logic              predicted_positive;
    logic              misclassified;
    logic [LOSS_W-1:0] loss_term;

    modport source (output valid, score, predicted_positive, misclassified,
                    loss_term, input ready);
    modport sink   (input valid, score, predicted_positive, misclassified,
                    loss_term, output ready);
endinterface

### hw/rtl/pcu_ram.sv
// Generic single-write, single-read RAM with registered (read-first) output.
// No dependencies.
module pcu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 40,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/pcu_fifo.sv
// Result queue: holds finished classifications until the sink takes them.
// Depends on pcu_pkg and pcu_rsp_if.
module pcu_fifo import pcu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_result   i_data,
    output logic      o_pop,
    pcu_rsp_if.source o_rsp
);
    t_result              r_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wptr;
    logic [OUT_PTR_W-1:0] r_rptr;
    logic [OUT_CNT_W-1:0] r_cnt;
    logic                 w_pop;
    t_result              w_head;

    assign w_head = r_mem[r_rptr];
    assign w_pop  = o_rsp.valid && o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_rsp.valid              = (r_cnt != '0);
    assign o_rsp.score              = w_head.score;
    assign o_rsp.predicted_positive = w_head.pred;
    assign o_rsp.misclassified      = w_head.miss;
    assign o_rsp.loss_term          = w_head.loss;
    assign o_pop                    = w_pop;
endmodule

### hw/rtl/perceptron_classify_update.sv
// Perceptron classify/update engine. A result reaches o_rsp through the stages
// and the result queue after its last classify request is taken. One request per
// cycle while i_req.ready is high (one weight read and one write-back or multiply).
// Reset (synchronous, active low) clears bias, running sum, queue and the
// per-entry valid bits, so all weights read as zero at once; no clearing pass.
// Depends on pcu_pkg, pcu_req_if, pcu_rsp_if, pcu_ram and pcu_fifo.
module perceptron_classify_update import pcu_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    pcu_req_if.sink   i_req,
    pcu_rsp_if.source o_rsp
);
    // ------------------------------------------------------------------
    // Request intake and flow control.
    // r_pend counts result-bearing requests taken but not yet delivered;
    // it never exceeds the queue depth, so the pipeline never has to stall.
    // ------------------------------------------------------------------
    logic                 w_acc;
    logic                 w_pop;
    logic                 w_res_in;
    logic [OUT_CNT_W-1:0] r_pend;

    assign i_req.ready = (r_pend < OUT_CNT_W'(OUT_DEPTH));
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_res_in    = w_acc && (i_req.command == CMD_CLASSIFY) && i_req.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            case ({w_res_in, w_pop})
                2'b10:   r_pend <= r_pend + 1'b1;
                2'b01:   r_pend <= r_pend - 1'b1;
                default: r_pend <= r_pend;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Weight RAM. Read is issued straight from the request port; data is
    // back in stage 1, where an update writes the new weight in place.
    // ------------------------------------------------------------------
    t_addr   w_raddr;
    t_weight w_rdata;
    logic    w_we;
    t_weight n_weight;
    t_addr   r_s1_addr;

    assign w_raddr = ADDR_W'(i_req.feature_index);

    pcu_ram #(
        .WIDTH (W_W),
        .DEPTH (FEATURES)
    ) u_wram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_s1_addr),
        .i_wdata (n_weight),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 1: resolve the weight, then either write back or multiply.
    // ------------------------------------------------------------------
    logic          r_s1_valid;
    logic          r_s1_cmd;
    logic          r_s1_inr;
    t_feat         r_s1_feat;
    logic          r_s1_pos;
    logic          r_s1_last;

    // one-deep write-back forward: covers a read issued in the same cycle
    // as the write to that entry (RAM returns the old word then)
    logic          r_wb_valid;
    t_addr         r_wb_addr;
    t_weight       r_wb_data;

    logic [FEATURES-1:0] r_wvld;   // entry written since reset
    t_weight       r_bias;

    t_weight              w_cur;
    logic                 w_fwd;
    logic signed [W_W:0]  w_feat_x;
    logic signed [W_W:0]  w_delta;
    t_sum                 w_prod;
    logic                 w_upd;

    always_ff @(posedge i_clk) begin
        r_s1_cmd  <= i_req.command;
        r_s1_addr <= w_raddr;
        r_s1_inr  <= (i_req.feature_index < FEATURES);
        r_s1_feat <= i_req.feature_value;
        r_s1_pos  <= i_req.label_positive;
        r_s1_last <= i_req.last;
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_acc;
        end
    end

    assign w_fwd = r_wb_valid && (r_wb_addr == r_s1_addr);

    always_comb begin
        if (!r_s1_inr) begin
            w_cur = '0;
        end else if (w_fwd) begin
            w_cur = r_wb_data;
        end else if (r_wvld[r_s1_addr]) begin
            w_cur = w_rdata;
        end else begin
            w_cur = '0;
        end
    end

    assign w_upd    = r_s1_valid && (r_s1_cmd == CMD_UPDATE);
    assign w_we     = w_upd && r_s1_inr;
    assign w_feat_x = (W_W + 1)'(r_s1_feat);
    assign w_delta  = r_s1_pos ? w_feat_x : -w_feat_x;
    assign n_weight = sat_weight({w_cur[W_W-1], w_cur} + w_delta);
    // Q8.8 times Q24.8 is exact in Q32.16
    assign w_prod   = r_s1_feat * w_cur;

    always_ff @(posedge i_clk) begin
        r_wb_addr <= r_s1_addr;
        r_wb_data <= n_weight;
        if (!i_rst_n) begin
            r_wb_valid <= 1'b0;
            r_wvld     <= '0;
            r_bias     <= '0;
        end else begin
            r_wb_valid <= w_we;
            if (w_we) begin
                r_wvld[r_s1_addr] <= 1'b1;
            end
            if (w_upd && r_s1_last) begin
                r_bias <= sat_weight({r_bias[W_W-1], r_bias} +
                                     (r_s1_pos ? BIAS_STEP : -BIAS_STEP));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: saturating accumulate. The bias is sampled in stage 1 so a
    // later update cannot leak into an earlier sample's score.
    // ------------------------------------------------------------------
    logic    r_s2_valid;
    logic    r_s2_last;
    logic    r_s2_pos;
    t_sum    r_s2_prod;
    t_weight r_s2_bias;
    t_sum    r_sum;
    t_sum    n_sum;

    always_ff @(posedge i_clk) begin
        r_s2_last <= r_s1_last;
        r_s2_pos  <= r_s1_pos;
        r_s2_prod <= w_prod;
        r_s2_bias <= r_bias;
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid && (r_s1_cmd == CMD_CLASSIFY);
        end
    end

    assign n_sum = sat_sum({r_sum[SUM_W-1], r_sum} + {r_s2_prod[SUM_W-1], r_s2_prod});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (r_s2_valid) begin
            r_sum <= r_s2_last ? '0 : n_sum;   // sample done: restart
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: add bias (Q24.8 -> Q32.16) to the finished sum.
    // ------------------------------------------------------------------
    logic    r_s3_valid;
    logic    r_s3_pos;
    t_sum    r_s3_acc;
    t_weight r_s3_bias;
    t_sum    w_bias_x;
    t_sum    n_score;

    always_ff @(posedge i_clk) begin
        r_s3_pos  <= r_s2_pos;
        r_s3_acc  <= n_sum;
        r_s3_bias <= r_s2_bias;
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid && r_s2_last;
        end
    end

    assign w_bias_x = {{(SUM_W - W_W - 8){r_s3_bias[W_W-1]}}, r_s3_bias, 8'b0};
    assign n_score  = sat_sum({r_s3_acc[SUM_W-1], r_s3_acc} +
                              {w_bias_x[SUM_W-1], w_bias_x});

    // ------------------------------------------------------------------
    // Stage 4: sign, label check and perceptron loss, then into the queue.
    // ------------------------------------------------------------------
    logic    r_s4_valid;
    logic    r_s4_pos;
    t_sum    r_s4_score;
    logic    w_pred;
    logic    w_miss;
    t_sum    w_neg;
    t_sum    w_loss;
    t_result w_res;

    always_ff @(posedge i_clk) begin
        r_s4_pos   <= r_s3_pos;
        r_s4_score <= n_score;
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else begin
            r_s4_valid <= r_s3_valid;
        end
    end

    assign w_pred = !r_s4_score[SUM_W-1] && (r_s4_score != '0);
    assign w_miss = (w_pred != r_s4_pos);
    // negating the most negative score clamps to the top
    assign w_neg  = (r_s4_score == SUM_MIN) ? SUM_MAX : -r_s4_score;

    always_comb begin
        if (!w_miss) begin
            w_loss = '0;
        end else if (r_s4_pos) begin
            w_loss = w_neg;        // score <= 0 here
        end else begin
            w_loss = r_s4_score;   // score > 0 here
        end
    end

    assign w_res.score = r_s4_score;
    assign w_res.pred  = w_pred;
    assign w_res.miss  = w_miss;
    assign w_res.loss  = w_loss[LOSS_W-1:0];

    pcu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s4_valid),
        .i_data  (w_res),
        .o_pop   (w_pop),
        .o_rsp   (o_rsp)
    );
endmodule
